### sv/bsrt_pkg.sv
package bsrt_pkg;

  // Default geometry
  localparam int BSRT_DEPTH       = 256;
  localparam int BSRT_SECTOR_BITS = 48;

  // Fixed field widths
  localparam int SECTOR_W    = 48;
  localparam int REASON_W    = 16;
  localparam int TIME_W      = 32;
  localparam int ACC_W       = 32;
  localparam int TOTAL_W     = 32;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int COUNT_OUT_W = 9;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 9'd256;
  localparam logic [ACC_W-1:0] ACC_MAX         = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 1'b1;

  // Request types
  localparam logic REQ_MAP = 1'b0;
  localparam logic REQ_ADD = 1'b1;

  typedef enum logic [1:0] {
    ST_MAPPED = 2'd0,
    ST_KILLED = 2'd1,
    ST_ADDED  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic                req_type;
    logic [SECTOR_W-1:0] sector;
    logic [SECTOR_W-1:0] repl_sector;
    logic [REASON_W-1:0] reason;
    logic                is_write;
    logic [TIME_W-1:0]   now_seconds;
  } bsrt_in_t;

  typedef struct packed {
    logic [SECTOR_W-1:0]    dest_sector;
    status_e                status;
    logic                   hit;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [SECTOR_W-1:0]    next_spare;
    logic                   dirty;
    logic [TOTAL_W-1:0]     read_total;
    logic [TOTAL_W-1:0]     write_total;
  } bsrt_out_t;

  // Update command from the sequencer to the statistics registers
  typedef struct packed {
    logic                add;
    logic                map_rd;
    logic                map_wr;
    logic [SECTOR_W-1:0] spare;
  } bsrt_upd_t;

  // Post-update totals reported with a result
  typedef struct packed {
    logic [SECTOR_W-1:0] next_spare;
    logic                dirty;
    logic [TOTAL_W-1:0]  reads;
    logic [TOTAL_W-1:0]  writes;
  } bsrt_tot_t;

endpackage

### sv/bsrt_ram.sv
module bsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bsrt_stats.sv
module bsrt_stats import bsrt_pkg::*; #(
  parameter int TABLE_DEPTH = BSRT_DEPTH,
  parameter int SECTOR_BITS = BSRT_SECTOR_BITS,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  bsrt_upd_t            upd_i,
  output logic [CNT_W-1:0]     cnt_o,
  output logic [CNT_W-1:0]     cnt_nxt_o,
  output logic                 full_o,
  output logic                 enabled_o,
  output bsrt_tot_t            tot_o
);

  localparam int SW    = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

  logic [CFG_W-1:0]   max_q;
  logic               en_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SW-1:0]      nsp_q, nsp_d;
  logic               dirty_q, dirty_d;
  logic [TOTAL_W-1:0] rd_q, rd_d;
  logic [TOTAL_W-1:0] wr_q, wr_d;
  logic [CMP_W-1:0]   lim;
  logic [CMP_W-1:0]   max_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_ENTRIES_RST;
      en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_ENTRIES: max_q <= cfg_wdata_i;
        CFG_ENABLED:     en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A limit above the table depth acts as the depth
  assign max_ext = CMP_W'(max_q);
  assign lim     = (max_ext > DEPTH_C) ? DEPTH_C : max_ext;
  assign full_o  = (CMP_W'(cnt_q) >= lim);

  always_comb begin
    cnt_d   = cnt_q;
    nsp_d   = nsp_q;
    dirty_d = dirty_q;
    rd_d    = rd_q;
    wr_d    = wr_q;
    if (upd_i.add) begin
      cnt_d   = cnt_q + CNT_W'(1);
      nsp_d   = upd_i.spare[SW-1:0] + SW'(1);
      dirty_d = 1'b1;
    end
    if (upd_i.map_rd) begin
      rd_d = rd_q + TOTAL_W'(1);
    end
    if (upd_i.map_wr) begin
      wr_d = wr_q + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      nsp_q   <= '0;
      dirty_q <= 1'b0;
      rd_q    <= '0;
      wr_q    <= '0;
    end else begin
      cnt_q   <= cnt_d;
      nsp_q   <= nsp_d;
      dirty_q <= dirty_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
    end
  end

  assign cnt_o            = cnt_q;
  assign cnt_nxt_o        = cnt_d;
  assign enabled_o        = en_q;
  assign tot_o.next_spare = SECTOR_W'(nsp_d);
  assign tot_o.dirty      = dirty_d;
  assign tot_o.reads      = rd_d;
  assign tot_o.writes     = wr_d;

endmodule

### sv/bad_sector_remap_table_unit.sv
// Channel   Handshake                  Payload       Beat
// cfg       cfg_we_i                   cfg_idx_i,    one register write
//                                      cfg_wdata_i
// in        in_valid_i / in_ready_o    in_data_i     one add or map request
// out       out_valid_o / out_ready_i  out_data_o    one result
//
// Add and killed map: EXEC, then DONE. Map: EXEC, then SCAN over the stored entries,
// then on a hit MRD and MWR to bump the access count, then DONE; the key memory gives one
// entry per cycle.
// Reset zeroes the counters and sets limit 256, enabled; no memory clearing pass.
// One request at a time; the next is taken once the result sits in the output
// register, even while that register waits on out_ready_i.
module bad_sector_remap_table_unit import bsrt_pkg::*; #(
  parameter int TABLE_DEPTH = BSRT_DEPTH,
  parameter int SECTOR_BITS = BSRT_SECTOR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bsrt_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bsrt_out_t            out_data_o
);

  localparam int SW     = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
  localparam int KEY_W  = 2 * SW;
  localparam int META_W = ACC_W + REASON_W + TIME_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_MRD    = 6'b001000,
    S_MWR    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  bsrt_in_t         req_q, req_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic             hit_q, hit_d;
  logic [AW-1:0]    hit_idx_q, hit_idx_d;
  logic [SW-1:0]    map_q, map_d;
  status_e          stat_q, stat_d;
  bsrt_out_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic              key_we, meta_we;
  logic [AW-1:0]     key_waddr;
  logic [KEY_W-1:0]  key_wdata, key_rdata;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic [SW-1:0]     key_orig, key_spare;
  logic [ACC_W-1:0]  acc_old;

  logic [CNT_W-1:0] cnt, cnt_nxt;
  logic [CMP_W-1:0] cnt_ext;
  logic             full, enabled;
  bsrt_upd_t        upd;
  bsrt_tot_t        tot;
  logic             leave;

  assign key_orig  = key_rdata[KEY_W-1:SW];
  assign key_spare = key_rdata[SW-1:0];
  assign acc_old   = meta_rdata[META_W-1:REASON_W+TIME_W];
  assign leave     = !out_valid_q || out_ready_i;
  assign cnt_ext   = CMP_W'(cnt_nxt);
  assign key_waddr = cnt[AW-1:0];

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    map_d       = map_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    key_we      = 1'b0;
    key_wdata   = {req_q.sector[SW-1:0], req_q.repl_sector[SW-1:0]};
    meta_we     = 1'b0;
    meta_wdata  = {{ACC_W{1'b0}}, req_q.reason, req_q.now_seconds};
    upd         = '0;
    upd.spare   = req_q.repl_sector;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        hit_d  = 1'b0;
        map_d  = '0;
        idx_d  = '0;
        pend_d = 1'b0;
        if (req_q.req_type == REQ_ADD) begin
          stat_d  = full ? ST_FULL : ST_ADDED;
          state_d = S_DONE;
        end else if (!enabled) begin
          stat_d  = ST_KILLED;
          state_d = S_DONE;
        end else begin
          stat_d  = ST_MAPPED;
          map_d   = req_q.sector[SW-1:0];
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Compare last cycle's entry while fetching the next one
        if (pend_q && key_orig == req_q.sector[SW-1:0]) begin
          hit_d     = 1'b1;
          map_d     = key_spare;
          hit_idx_d = pend_idx_q;
          pend_d    = 1'b0;
          state_d   = S_MRD;
        end else if (idx_q < cnt) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q[AW-1:0];
          idx_d      = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_MRD: begin
        state_d = S_MWR;
      end
      S_MWR: begin
        // Bump the access count, saturating
        meta_we    = 1'b1;
        meta_wdata = {(acc_old == ACC_MAX) ? acc_old : acc_old + ACC_W'(1),
                      meta_rdata[REASON_W+TIME_W-1:0]};
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (leave) begin
          upd.add    = (stat_q == ST_ADDED);
          upd.map_rd = (stat_q == ST_MAPPED) && !req_q.is_write;
          upd.map_wr = (stat_q == ST_MAPPED) && req_q.is_write;
          key_we     = (stat_q == ST_ADDED);
          meta_we    = (stat_q == ST_ADDED);
          out_d.dest_sector   = SECTOR_W'(map_q);
          out_d.status        = stat_q;
          out_d.hit           = hit_q;
          out_d.entry_count   = cnt_ext[COUNT_OUT_W-1:0];
          out_d.next_spare    = tot.next_spare;
          out_d.dirty         = tot.dirty;
          out_d.read_total    = tot.reads;
          out_d.write_total   = tot.writes;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    map_q      <= map_d;
    stat_q     <= stat_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bsrt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (key_rdata)
  );

  bsrt_ram #(
    .WIDTH (META_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i ((state_q == S_MWR) ? hit_idx_q : key_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (hit_idx_q),
    .rdata_o (meta_rdata)
  );

  bsrt_stats #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS),
    .CNT_W       (CNT_W)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_i       (upd),
    .cnt_o       (cnt),
    .cnt_nxt_o   (cnt_nxt),
    .full_o      (full),
    .enabled_o   (enabled),
    .tot_o       (tot)
  );

endmodule

### verif/testbench.sv
module testbench;
  import bsrt_pkg::*;

  localparam logic [SECTOR_W-1:0] TOP_SECTOR = '1;

  typedef struct packed {
    logic             is_cfg;
    logic [CFG_W-1:0] lim;
    logic             en;
    logic             typed;
    bsrt_in_t         rq;
    bsrt_out_t        res;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MAX_ENTRIES;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  bsrt_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  bsrt_out_t        out_data;

  // Shadow of the remap table and its counters
  logic [SECTOR_W-1:0] tab_orig [BSRT_DEPTH];
  logic [SECTOR_W-1:0] tab_spare [BSRT_DEPTH];
  logic [ACC_W-1:0]    tab_hits [BSRT_DEPTH];
  logic [COUNT_OUT_W-1:0] n_entries = '0;
  logic [SECTOR_W-1:0] spare_hint = '0;
  logic                tab_dirty = 1'b0;
  logic [TOTAL_W-1:0]  rd_total = '0;
  logic [TOTAL_W-1:0]  wr_total = '0;
  logic [CFG_W-1:0]    cur_limit = MAX_ENTRIES_RST;
  logic                cur_enabled = 1'b1;

  bsrt_out_t outcome_q[$];
  int        bad_outcomes = 0;
  int        snd_idle_pct = 0;
  int        rcv_stall_pct = 0;

  bad_sector_remap_table_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  function automatic bsrt_out_t remap_outcome(bsrt_in_t rq);
    bsrt_out_t   o;
    int unsigned lim;
    bit          found;
    o = '0;
    found = 1'b0;
    lim = (cur_limit > BSRT_DEPTH) ? BSRT_DEPTH : cur_limit;
    if (rq.req_type == REQ_ADD) begin
      if (n_entries >= lim) begin
        o.status = ST_FULL;
      end else begin
        tab_orig[n_entries] = rq.sector;
        tab_spare[n_entries] = rq.repl_sector;
        tab_hits[n_entries] = '0;
        n_entries = n_entries + 9'd1;
        spare_hint = rq.repl_sector + 48'd1;
        tab_dirty = 1'b1;
        o.status = ST_ADDED;
      end
    end else if (!cur_enabled) begin
      o.status = ST_KILLED;
    end else begin
      o.dest_sector = rq.sector;
      // first match wins
      for (int i = 0; i < n_entries && !found; i++) begin
        if (tab_orig[i] == rq.sector) begin
          found = 1'b1;
          o.dest_sector = tab_spare[i];
          o.hit = 1'b1;
          if (tab_hits[i] != ACC_MAX) tab_hits[i] = tab_hits[i] + 32'd1;
        end
      end
      if (rq.is_write) wr_total = wr_total + 32'd1;
      else rd_total = rd_total + 32'd1;
      o.status = ST_MAPPED;
    end
    o.entry_count = n_entries;
    o.next_spare = spare_hint;
    o.dirty = tab_dirty;
    o.read_total = rd_total;
    o.write_total = wr_total;
    return o;
  endfunction

  function automatic logic [SECTOR_W-1:0] rand_sector();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = {60'd0, w[3:0]};
      default: ;
    endcase
    return w[SECTOR_W-1:0];
  endfunction

  function automatic bsrt_in_t rand_request(int add_pct);
    bsrt_in_t    rq;
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    rq.req_type = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_MAP;
    rq.sector = rand_sector();
    rq.repl_sector = rand_sector();
    rq.reason = w[15:0];
    rq.is_write = w[16];
    rq.now_seconds = w[63:32];
    // steer toward stored sectors: lookups hit, adds make duplicates
    if (n_entries != 0 && $urandom_range(99) < ((rq.req_type == REQ_MAP) ? 60 : 15))
      rq.sector = tab_orig[$urandom_range(n_entries - 1)];
    return rq;
  endfunction

  function automatic plan_row_t cfg_to(logic [CFG_W-1:0] lim, logic en);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.lim = lim;
    r.en = en;
    return r;
  endfunction

  function automatic plan_row_t ask(logic rt, logic [SECTOR_W-1:0] sec,
                                    logic [SECTOR_W-1:0] spr, logic [REASON_W-1:0] rsn,
                                    logic wr, logic [TIME_W-1:0] now);
    plan_row_t r;
    r = '0;
    r.rq.req_type = rt;
    r.rq.sector = sec;
    r.rq.repl_sector = spr;
    r.rq.reason = rsn;
    r.rq.is_write = wr;
    r.rq.now_seconds = now;
    return r;
  endfunction

  function automatic plan_row_t with_res(plan_row_t r, logic [SECTOR_W-1:0] m, status_e st,
                                         logic h, logic [COUNT_OUT_W-1:0] cnt,
                                         logic [SECTOR_W-1:0] ns, logic d,
                                         logic [TOTAL_W-1:0] rd, logic [TOTAL_W-1:0] wr);
    r.typed = 1'b1;
    r.res.dest_sector = m;
    r.res.status = st;
    r.res.hit = h;
    r.res.entry_count = cnt;
    r.res.next_spare = ns;
    r.res.dirty = d;
    r.res.read_total = rd;
    r.res.write_total = wr;
    return r;
  endfunction

  task automatic show_outcome(string tag, bsrt_out_t o);
    $display("%s map=%h st=%0d hit=%b cnt=%0d spare=%h dirty=%b rd=%0d wr=%0d", tag,
             o.dest_sector, o.status, o.hit, o.entry_count, o.next_spare, o.dirty,
             o.read_total, o.write_total);
  endtask

  task automatic send_req(bsrt_in_t rq, logic typed, bsrt_out_t res);
    bsrt_out_t o;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    o = remap_outcome(rq);
    outcome_q.push_back(typed ? res : o);
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  task automatic set_cfg(logic [CFG_W-1:0] lim, logic en);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MAX_ENTRIES;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_idx <= CFG_ENABLED;
    cfg_wdata <= {{(CFG_W-1){1'b0}}, en};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_limit = lim;
    cur_enabled = en;
  endtask

  task automatic run_phase(int n, int add_pct, logic [CFG_W-1:0] lim, logic en,
                           int idle, int stall, int pause_every);
    drain();
    snd_idle_pct = idle;
    rcv_stall_pct = stall;
    set_cfg(lim, en);
    for (int k = 0; k < n; k++) begin
      if (pause_every != 0 && k % pause_every == pause_every - 1) drain();
      send_req(rand_request(add_pct), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin : take_result
    bsrt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        bad_outcomes++;
        if (bad_outcomes <= 10) show_outcome("unexpected beat:", out_data);
      end else begin
        want = outcome_q.pop_front();
        if (want.dest_sector !== out_data.dest_sector ||
            want.status !== out_data.status || want.hit !== out_data.hit ||
            want.entry_count !== out_data.entry_count ||
            want.next_spare !== out_data.next_spare || want.dirty !== out_data.dirty ||
            want.read_total !== out_data.read_total ||
            want.write_total !== out_data.write_total) begin
          bad_outcomes++;
          if (bad_outcomes <= 10) begin
            show_outcome("mismatch, expected:", want);
            show_outcome("          actual:  ", out_data);
          end
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    // extremes of every field, hits, duplicates, disable and limit corners
    plan.push_back(with_res(ask(REQ_MAP, '0, '0, '0, 1'b0, '0),
                            '0, ST_MAPPED, 1'b0, 9'd0, '0, 1'b0, 32'd1, 32'd0));
    plan.push_back(with_res(ask(REQ_MAP, TOP_SECTOR, TOP_SECTOR, '1, 1'b1, '1),
                            TOP_SECTOR, ST_MAPPED, 1'b0, 9'd0, '0, 1'b0, 32'd1, 32'd1));
    // spare of all ones wraps the hint to zero
    plan.push_back(with_res(ask(REQ_ADD, 48'd5, TOP_SECTOR, '1, 1'b1, '1),
                            '0, ST_ADDED, 1'b0, 9'd1, '0, 1'b1, 32'd1, 32'd1));
    plan.push_back(with_res(ask(REQ_MAP, 48'd5, '0, '0, 1'b0, '0),
                            TOP_SECTOR, ST_MAPPED, 1'b1, 9'd1, '0, 1'b1, 32'd2, 32'd1));
    plan.push_back(with_res(ask(REQ_ADD, 48'd5, 48'd100, '0, 1'b0, '0),
                            '0, ST_ADDED, 1'b0, 9'd2, 48'd101, 1'b1, 32'd2, 32'd1));
    plan.push_back(with_res(ask(REQ_MAP, 48'd5, '0, '0, 1'b1, '0),
                            TOP_SECTOR, ST_MAPPED, 1'b1, 9'd2, 48'd101, 1'b1, 32'd2, 32'd2));
    plan.push_back(with_res(ask(REQ_ADD, TOP_SECTOR, '0, 16'h1234, 1'b0, 32'd77),
                            '0, ST_ADDED, 1'b0, 9'd3, 48'd1, 1'b1, 32'd2, 32'd2));
    plan.push_back(with_res(ask(REQ_MAP, TOP_SECTOR, TOP_SECTOR, '0, 1'b0, '0),
                            '0, ST_MAPPED, 1'b1, 9'd3, 48'd1, 1'b1, 32'd3, 32'd2));
    plan.push_back(ask(REQ_MAP, 48'd6, '0, '0, 1'b0, '0));
    plan.push_back(cfg_to(9'd256, 1'b0));
    plan.push_back(with_res(ask(REQ_MAP, 48'd5, '0, '0, 1'b1, '0),
                            '0, ST_KILLED, 1'b0, 9'd3, 48'd1, 1'b1, 32'd4, 32'd2));
    plan.push_back(with_res(ask(REQ_ADD, 48'd7, 48'd7, 16'd1, 1'b0, 32'd1),
                            '0, ST_ADDED, 1'b0, 9'd4, 48'd8, 1'b1, 32'd4, 32'd2));
    plan.push_back(cfg_to(9'd0, 1'b1));
    plan.push_back(with_res(ask(REQ_ADD, 48'd9, 48'd9, 16'd2, 1'b1, 32'd2),
                            '0, ST_FULL, 1'b0, 9'd4, 48'd8, 1'b1, 32'd4, 32'd2));
    plan.push_back(cfg_to(9'd2, 1'b1));
    plan.push_back(with_res(ask(REQ_ADD, 48'd9, 48'd9, 16'd2, 1'b0, 32'd2),
                            '0, ST_FULL, 1'b0, 9'd4, 48'd8, 1'b1, 32'd4, 32'd2));
    plan.push_back(ask(REQ_MAP, 48'd7, '0, '0, 1'b0, '0));
    plan.push_back(cfg_to(9'h1FF, 1'b1));
    plan.push_back(with_res(ask(REQ_ADD, 48'd9, 48'd20, 16'd3, 1'b0, 32'd3),
                            '0, ST_ADDED, 1'b0, 9'd5, 48'd21, 1'b1, 32'd5, 32'd2));
    plan.push_back(ask(REQ_MAP, 48'd9, '0, '0, 1'b1, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        set_cfg(plan[i].lim, plan[i].en);
      end else begin
        send_req(plan[i].rq, plan[i].typed, plan[i].res);
      end
    end

    run_phase(180, 45, 9'd256, 1'b1, 0, 0, 0);
    run_phase(180, 45, 9'd300, 1'b1, 70, 0, 0);
    run_phase(150, 40, 9'd256, 1'b0, 0, 70, 0);
    run_phase(120, 40, 9'd0, 1'b1, 34, 34, 0);
    run_phase(170, 50, 9'd256, 1'b1, 0, 0, 40);
    run_phase(100, 40, 9'd100, 1'b1, 34, 34, 0);

    drain();
    // wait out a full-table scan; watch for stray beats
    repeat (300) @(posedge clk);
    if (bad_outcomes == 0 && outcome_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
